// ===== rtl/core/sdq_pkg.sv =====
// Shared types and codes for the sorted deadline queue.
package sdq_pkg;

  localparam int unsigned DueW = 27;
  localparam int unsigned IdW  = 16;
  localparam int unsigned PosW = 4;

  // Operation selector carried on the input tuser
  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_READ     = 2'd2
  } kind_e;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NONE    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // One table entry
  typedef struct packed {
    logic [DueW-1:0] due;
    logic [IdW-1:0]  id;
    logic            done;
  } entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic            ins_en;
    logic            cmp_en;
    logic [DueW-1:0] new_due;
    logic [IdW-1:0]  new_id;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sdq_cell.sv =====
// One slot of the sorted table: compares, shifts from its left neighbor, marks done.
module sdq_cell (
  input  logic               clk_i,
  input  sdq_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,       // slot index below fill count
  input  logic               left_move_i,   // left neighbor shifts on insert
  input  sdq_pkg::entry_t    left_entry_i,
  input  logic               pend_before_i, // a pending entry sits to the left
  output logic               move_o,
  output logic               pend_o,
  output logic               hit_o,         // earliest pending entry is here
  output sdq_pkg::entry_t    entry_o
);
  import sdq_pkg::*;

  entry_t entry_q, entry_d;
  logic   pend_here;

  // Insert goes after every entry with an equal or earlier date
  assign move_o    = !(valid_i && (entry_q.due <= ctrl_i.new_due));
  assign pend_here = valid_i && !entry_q.done;
  assign pend_o    = pend_before_i || pend_here;
  assign hit_o     = pend_here && !pend_before_i;
  assign entry_o   = entry_q;

  // Next slot contents
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && move_o) begin
      if (left_move_i) begin
        entry_d = left_entry_i;
      end else begin
        entry_d.due  = ctrl_i.new_due;
        entry_d.id   = ctrl_i.new_id;
        entry_d.done = 1'b0;
      end
    end else if (ctrl_i.cmp_en && hit_o) begin
      entry_d.done = 1'b1;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/core/sorted_deadline_queue_top.sv =====
// Sorted deadline queue: top level with handshake, fill count, id counter and result register.
//
// Usage: each input word carries an operation in s_axis_tuser_i (insert, complete
// earliest pending, read position) with the due date and position in s_axis_tdata_i.
// Every insert, complete and read word yields exactly one result word on the master
// side; a word with the unused operation code is accepted and yields nothing.
// The result sits in the output register the cycle after the word is accepted.
// Throughput is one word per cycle while the master side keeps up; the slot cells
// compare and shift in parallel, so an insert's placement and a complete's search
// both finish in the accept cycle (set by the due-date compare in each cell and
// the pending priority chain across the row).
// The input is ready whenever the output register is empty or being drained, so a
// stall on the master side holds the result and stops intake until it is taken.
// Reset empties the table (fill count 0), sets the next id to 1 and drops any
// pending result; slot contents are not cleared and are never read unwritten.
// A full table rejects inserts with the full status and leaves the id unchanged.
module sorted_deadline_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // due_date[26:0], position[30:27], zero fill
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // task_id[15:0], entry_due[42:16],
                                        // entry_done[43], zero fill
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import sdq_pkg::*;

  localparam int unsigned FillW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned CmpW  = (FillW > PosW) ? FillW : PosW;

  logic [FillW-1:0] fill_q, fill_d;
  logic [IdW-1:0]   next_id_q, next_id_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [DueW-1:0]  due_q, due_d;
  logic             done_q, done_d;

  logic             accept;
  logic [1:0]       in_kind;
  logic [DueW-1:0]  in_due;
  logic [PosW-1:0]  in_pos;
  logic             is_full;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  fill_ext;
  logic [IdxW-1:0]  rd_idx;

  cell_ctrl_t       ctrl;
  logic             cell_move  [CAPACITY];
  logic             cell_pend  [CAPACITY];
  logic             cell_hit   [CAPACITY];
  logic             cell_valid [CAPACITY];
  entry_t           cell_entry [CAPACITY];
  entry_t           hit_entry;
  entry_t           rd_entry;

  // Input unpacking and handshake
  assign in_kind         = s_axis_tuser_i;
  assign in_due          = s_axis_tdata_i[DueW-1:0];
  assign in_pos          = s_axis_tdata_i[DueW+PosW-1:DueW];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full         = (fill_q == FillW'(CAPACITY));

  // Broadcast control to the row of cells
  always_comb begin
    ctrl.ins_en  = accept && (in_kind == KIND_INSERT) && !is_full;
    ctrl.cmp_en  = accept && (in_kind == KIND_COMPLETE);
    ctrl.new_due = in_due;
    ctrl.new_id  = next_id_q;
  end

  // Row of slot cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign cell_valid[g] = (FillW'(g) < fill_q);
    if (g == 0) begin : g_first
      sdq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .valid_i       (cell_valid[g]),
        .left_move_i   (1'b0),
        .left_entry_i  ('0),
        .pend_before_i (1'b0),
        .move_o        (cell_move[g]),
        .pend_o        (cell_pend[g]),
        .hit_o         (cell_hit[g]),
        .entry_o       (cell_entry[g])
      );
    end else begin : g_rest
      sdq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .valid_i       (cell_valid[g]),
        .left_move_i   (cell_move[g-1]),
        .left_entry_i  (cell_entry[g-1]),
        .pend_before_i (cell_pend[g-1]),
        .move_o        (cell_move[g]),
        .pend_o        (cell_pend[g]),
        .hit_o         (cell_hit[g]),
        .entry_o       (cell_entry[g])
      );
    end
  end

  // Gather the earliest pending entry (one-hot select)
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_hit[i]) begin
        hit_entry = hit_entry | cell_entry[i];
      end
    end
  end

  // Read select; index only used when position is below fill count
  assign pos_ext  = CmpW'(in_pos);
  assign fill_ext = CmpW'(fill_q);
  assign rd_idx   = pos_ext[IdxW-1:0];
  assign rd_entry = cell_entry[rd_idx];

  // Counters and result register next state
  always_comb begin
    fill_d      = fill_q;
    next_id_d   = next_id_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    status_d    = status_q;
    id_d        = id_q;
    due_d       = due_q;
    done_d      = done_q;
    if (accept) begin
      case (in_kind)
        KIND_INSERT: begin
          out_valid_d = 1'b1;
          if (is_full) begin
            status_d = ST_FULL;
            id_d     = '0;
            due_d    = '0;
            done_d   = 1'b0;
          end else begin
            fill_d    = fill_q + FillW'(1);
            next_id_d = (next_id_q == {IdW{1'b1}}) ? IdW'(1) : next_id_q + IdW'(1);
            status_d  = ST_OK;
            id_d      = next_id_q;
            due_d     = in_due;
            done_d    = 1'b0;
          end
        end
        KIND_COMPLETE: begin
          out_valid_d = 1'b1;
          if (cell_pend[CAPACITY-1]) begin
            status_d = ST_OK;
            id_d     = hit_entry.id;
            due_d    = hit_entry.due;
            done_d   = 1'b1;
          end else begin
            status_d = ST_NONE;
            id_d     = '0;
            due_d    = '0;
            done_d   = 1'b0;
          end
        end
        KIND_READ: begin
          out_valid_d = 1'b1;
          if (pos_ext < fill_ext) begin
            status_d = ST_OK;
            id_d     = rd_entry.id;
            due_d    = rd_entry.due;
            done_d   = rd_entry.done;
          end else begin
            status_d = ST_EMPTY;
            id_d     = '0;
            due_d    = '0;
            done_d   = 1'b0;
          end
        end
        default: begin
          // unused code: nothing changes, no result word
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      next_id_q   <= IdW'(1);
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    id_q     <= id_d;
    due_q    <= due_d;
    done_q   <= done_d;
  end

  // Output packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {4'b0, done_q, due_q, id_q};

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(CAPACITY))
    else $error("fill count above capacity");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("next id is zero");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_kind == KIND_INSERT) && is_full
    |=> (fill_q == $past(fill_q)) && (next_id_q == $past(next_id_q)))
    else $error("rejected insert changed table state");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ((in_kind == KIND_INSERT) || (in_kind == KIND_COMPLETE) ||
               (in_kind == KIND_READ))
    |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

endmodule
